FILE: src/fks_pkg.sv
// Shared constants, state encoding and controller/datapath structs for the
// greedy fractional knapsack block. No dependencies.
package fks_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	localparam int VAL_W  = 20;
	localparam int WGT_W  = 20;
	localparam int CAP_W  = 24;
	localparam int TOT_W  = 42;
	localparam int FRAC_W = 16;
	localparam int PROD_W = VAL_W + WGT_W;

	// Partial pick: floor((value * capacity) << 16 / weight).
	localparam int DVD_W      = PROD_W + FRAC_W;
	localparam int QUO_W      = VAL_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(DVD_W);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_KNAPSACK_CAPACITY = 1'b0;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PICK,
		ST_READ,
		ST_MUL,
		ST_CMP,
		ST_DECIDE,
		ST_DIV_MUL,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_ADD,
		ST_FINISH
	} fks_state_t;

	typedef struct packed {
		logic accept_en;
		logic pick_init;
		logic mul_en;
		logic cmp_en;
		logic take_whole;
		logic div_mul;
		logic div_load;
		logic div_step;
		logic div_add;
		logic finish;
	} fks_cmd_t;

	typedef struct packed {
		logic last_accepted;
		logic cap_zero;
		logic scan_done;
		logic found;
		logic fits;
		logic div_last;
		logic out_free;
	} fks_status_t;

endpackage

FILE: src/fks_if.sv
// Valid/ready channel interfaces for item input and result output.
// Depends on fks_pkg for field widths.
interface fks_item_if import fks_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] item_value;
	logic [WGT_W-1:0] item_weight;
	logic             last_item;

	modport source (output valid, output item_value, output item_weight, output last_item,
		input ready);
	modport sink (input valid, input item_value, input item_weight, input last_item,
		output ready);
endinterface

interface fks_result_if import fks_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TOT_W-1:0] total_value;
	logic             items_dropped;

	modport source (output valid, output total_value, output items_dropped, input ready);
	modport sink (input valid, input total_value, input items_dropped, output ready);
endinterface

FILE: src/fks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/fks_ctrl.sv
// Controller state machine for the greedy knapsack: sequences loading, the
// per-pick scan, whole or partial takes and result delivery. Uses fks_pkg.
module fks_ctrl import fks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fks_status_t status,
	output fks_cmd_t    cmd
);

	fks_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (status.last_accepted) state_d = ST_PICK;
			end
			ST_PICK: begin
				state_d = status.cap_zero ? ST_FINISH : ST_READ;
			end
			ST_READ: begin
				state_d = status.scan_done ? ST_DECIDE : ST_MUL;
			end
			ST_MUL: state_d = ST_CMP;
			ST_CMP: state_d = ST_READ;
			ST_DECIDE: begin
				if (!status.found) begin
					state_d = ST_FINISH;
				end else if (status.fits) begin
					state_d = ST_PICK;
				end else begin
					state_d = ST_DIV_MUL;
				end
			end
			ST_DIV_MUL:  state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV_STEP;
			ST_DIV_STEP: begin
				if (status.div_last) state_d = ST_DIV_ADD;
			end
			ST_DIV_ADD: state_d = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD:     cmd.accept_en = 1'b1;
			ST_PICK:     cmd.pick_init = 1'b1;
			ST_READ:     ;
			ST_MUL:      cmd.mul_en = 1'b1;
			ST_CMP:      cmd.cmp_en = 1'b1;
			ST_DECIDE:   cmd.take_whole = status.found && status.fits;
			ST_DIV_MUL:  cmd.div_mul = 1'b1;
			ST_DIV_LOAD: cmd.div_load = 1'b1;
			ST_DIV_STEP: cmd.div_step = 1'b1;
			ST_DIV_ADD:  cmd.div_add = 1'b1;
			ST_FINISH:   cmd.finish = status.out_free;
			default:     ;
		endcase
	end

endmodule

FILE: src/fks_dp.sv
// Datapath of the greedy knapsack: item stores, ratio compare, capacity and
// accumulator, bit-serial divider and output register. Uses fks_pkg, fks_ram, fks_if.
module fks_dp import fks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] knapsack_capacity,
	input  fks_cmd_t         cmd,
	output fks_status_t      status,
	fks_item_if.sink         item,
	fks_result_if.source     result
);

	logic [CNT_W-1:0] item_count_q;
	logic             overflow_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             found_q;
	logic [CAP_W-1:0] cap_left_q;
	logic [TOT_W-1:0] acc_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic             out_valid_q;

	logic [VAL_W-1:0]  best_v_q;
	logic [WGT_W-1:0]  best_w_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PROD_W-1:0] prod_a_s1;
	logic [PROD_W-1:0] prod_b_s1;
	logic [PROD_W-1:0] frac_prod_s1;
	logic [DVD_W-1:0]  dvd_q;
	logic [WGT_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [TOT_W-1:0]  total_q;
	logic              dropped_q;

	logic             accept;
	logic             room;
	logic [CNT_W-1:0] count_next;
	logic [VAL_W-1:0] value_rd;
	logic [WGT_W-1:0] weight_rd;
	logic             wgt_we;
	logic [IDX_W-1:0] wgt_waddr;
	logic [WGT_W-1:0] wgt_wdata;
	logic             better;
	logic [TOT_W-1:0] addend;
	logic [TOT_W:0]   acc_sum;
	logic [TOT_W-1:0] acc_sat;
	logic [WGT_W:0]   trial;
	logic             trial_ge;
	logic [WGT_W:0]   trial_diff;

	assign item.ready = cmd.accept_en;
	assign accept     = item.valid && item.ready;
	assign room       = item_count_q < CNT_W'(MAX_ITEMS);
	assign count_next = room ? item_count_q + CNT_W'(1) : item_count_q;

	assign wgt_we    = (accept && room) || cmd.take_whole;
	assign wgt_waddr = cmd.take_whole ? best_idx_q : item_count_q[IDX_W-1:0];
	assign wgt_wdata = cmd.take_whole ? '0 : item.item_weight;

	fks_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_value_ram (
		.clk   (clk),
		.we    (accept && room),
		.waddr (item_count_q[IDX_W-1:0]),
		.wdata (item.item_value),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (value_rd)
	);

	fks_ram #(.WIDTH(WGT_W), .DEPTH(MAX_ITEMS)) u_weight_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (wgt_wdata),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (weight_rd)
	);

	// Cross-multiplied ratio test; a later index wins a tie.
	assign better = (weight_rd != '0) && (!found_q || prod_a_s1 >= prod_b_s1);

	assign addend  = cmd.div_add ? TOT_W'(quo_q) : TOT_W'({best_v_q, {FRAC_W{1'b0}}});
	assign acc_sum = {1'b0, acc_q} + {1'b0, addend};
	assign acc_sat = acc_sum[TOT_W] ? {TOT_W{1'b1}} : acc_sum[TOT_W-1:0];

	// One restoring division step; the remainder always stays below the divisor.
	assign trial      = {rem_q, dvd_q[DVD_W-1]};
	assign trial_ge   = trial >= {1'b0, best_w_q};
	assign trial_diff = trial - {1'b0, best_w_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
			overflow_q   <= 1'b0;
			n_q          <= '0;
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			cap_left_q   <= '0;
			acc_q        <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				item_count_q <= count_next;
				if (!room) overflow_q <= 1'b1;
				if (item.last_item) begin
					n_q        <= count_next;
					scan_idx_q <= '0;
					cap_left_q <= knapsack_capacity;
					acc_q      <= '0;
				end
			end
			if (cmd.pick_init) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end
			if (cmd.cmp_en) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
				if (better) found_q <= 1'b1;
			end
			if (cmd.take_whole) begin
				acc_q      <= acc_sat;
				cap_left_q <= cap_left_q - CAP_W'(best_w_q);
			end
			if (cmd.div_load) div_cnt_q <= '0;
			if (cmd.div_step) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (cmd.div_add) begin
				acc_q      <= acc_sat;
				cap_left_q <= '0;
			end
			if (result.valid && result.ready) out_valid_q <= 1'b0;
			if (cmd.finish) begin
				out_valid_q  <= 1'b1;
				item_count_q <= '0;
				overflow_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_a_s1 <= value_rd * best_w_q;
			prod_b_s1 <= best_v_q * weight_rd;
		end
		if (cmd.cmp_en && better) begin
			best_v_q   <= value_rd;
			best_w_q   <= weight_rd;
			best_idx_q <= scan_idx_q[IDX_W-1:0];
		end
		if (cmd.div_mul) begin
			frac_prod_s1 <= best_v_q * cap_left_q[WGT_W-1:0];
		end
		if (cmd.div_load) begin
			dvd_q <= {frac_prod_s1, {FRAC_W{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= trial_ge ? trial_diff[WGT_W-1:0] : trial[WGT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
		if (cmd.finish) begin
			total_q   <= acc_q;
			dropped_q <= overflow_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.total_value   = total_q;
	assign result.items_dropped = dropped_q;

	always_comb begin
		status               = '0;
		status.last_accepted = accept && item.last_item;
		status.cap_zero      = cap_left_q == '0;
		status.scan_done     = scan_idx_q == n_q;
		status.found         = found_q;
		status.fits          = cap_left_q >= CAP_W'(best_w_q);
		status.div_last      = div_cnt_q == DIV_CNT_W'(DVD_W - 1);
		status.out_free      = !out_valid_q;
	end

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_idx_q <= n_q && n_q <= CNT_W'(MAX_ITEMS))
		else $error("scan index ran past the stored item count");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < best_w_q)
		else $error("division remainder not below divisor");

	a_take_needs_fit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_whole |-> found_q && best_w_q != '0 && cap_left_q >= CAP_W'(best_w_q))
		else $error("whole take without a fitting chosen item");

	a_partial_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_mul |-> cap_left_q < CAP_W'(best_w_q) && cap_left_q != '0)
		else $error("partial take with capacity out of range");

	a_finish_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && item_count_q == '0 && !overflow_q)
		else $error("result not posted or set state not cleared");

endmodule

FILE: src/fractional_knapsack_greedy.sv
// Top level of the greedy fractional knapsack: APB capacity register,
// controller and datapath. Uses fks_pkg, fks_if, fks_ctrl and fks_dp.
//
// Items are loaded at one transaction per cycle while the block is loading;
// a store holds up to MAX_ITEMS (64) items, and further items of the set are
// dropped and reported through items_dropped. The transaction that carries
// last_item starts the fill, which samples knapsack_capacity (APB offset 0).
// Each greedy pick scans the n stored items through the single read port of
// the item stores, one item at a time in three steps (read, multiply,
// compare), and up to n picks are made; a final partial pick runs the
// bit-serial divider. The result sits in an output register; loading of the
// next set proceeds while it waits to be taken. The stores need no clearing
// after reset.
module fractional_knapsack_greedy import fks_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	fks_item_if.sink           item,
	fks_result_if.source       result
);

	logic [CAP_W-1:0] knapsack_capacity_q;
	fks_cmd_t         cmd;
	fks_status_t      status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knapsack_capacity_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_KNAPSACK_CAPACITY) begin
			knapsack_capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_KNAPSACK_CAPACITY: prdata = PDATA_W'(knapsack_capacity_q);
			default:               prdata = '0;
		endcase
	end

	fks_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	fks_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.knapsack_capacity (knapsack_capacity_q),
		.cmd               (cmd),
		.status            (status),
		.item              (item),
		.result            (result)
	);

endmodule

FILE: sim/tb_fractional_knapsack_greedy.sv
// Self-checking testbench for the greedy fractional knapsack block: a directed table, then
// random data sets under several capacities, each result checked by predictor or hand value.
// Depends on fks_pkg, fks_item_if, fks_result_if and fractional_knapsack_greedy.
module tb_fractional_knapsack_greedy;
	import fks_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 8;
	localparam int RANDOM_ITEMS  = 750;
	localparam int RANDOM_PHASES = 6;
	localparam int HOLD_CYCLES   = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 200;
	localparam int STALL_LIMIT   = 60000;
	localparam int N_DIRECTED    = 19;

	localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'({REG_KNAPSACK_CAPACITY, 2'b00});
	localparam logic [63:0]        TOT_MAX  = (64'd1 << TOT_W) - 64'd1;
	localparam logic [CAP_W-1:0]   CAP_MAX  = '1;
	localparam logic [VAL_W-1:0]   VAL_MAX  = '1;
	localparam logic [WGT_W-1:0]   WGT_MAX  = '1;

	typedef struct packed {
		logic [TOT_W-1:0] total;
		logic             dropped;
	} loot_t;

	// One row per item; cap is applied only on the first row of a data set.
	typedef struct packed {
		logic [CAP_W-1:0] cap;
		logic [VAL_W-1:0] value;
		logic [WGT_W-1:0] weight;
		logic             last;
		logic             hand_exp;
		logic [TOT_W-1:0] hand_total;
		logic             hand_dropped;
	} directed_row_t;

	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	fks_item_if   item_bus ();
	fks_result_if result_bus ();

	fractional_knapsack_greedy dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_bus),
		.result  (result_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state: the bench's own copy of the item store and the capacity register.
	logic [VAL_W-1:0] held_val [MAX_ITEMS];
	logic [WGT_W-1:0] held_wgt [MAX_ITEMS];
	int               held_cnt;
	bit               spill_seen;
	logic [CAP_W-1:0] capacity_model;

	loot_t         loot_q[$];
	directed_row_t directed_tab [N_DIRECTED];

	int  fail_cnt;
	int  burst_left;
	bit  hold_req;
	int  items_sent;
	int  sets_done;
	int  sets_spilled;
	int  partial_picks;
	int  cap_writes;
	int  results_seen;

	// Greedy fill over the held items; zeroes the weight of each item taken whole, as the hardware does.
	function automatic logic [TOT_W-1:0] greedy_total();
		logic [CAP_W-1:0] room;
		logic [63:0] acc;
		logic [63:0] gain;
		logic [63:0] lhs;
		logic [63:0] rhs;
		int best;
		bit found;
		acc = '0;
		room = capacity_model;
		while (room != 0) begin
			found = 1'b0;
			best = 0;
			for (int i = 0; i < held_cnt; i++) begin
				if (held_wgt[i] != 0) begin
					lhs = 64'(held_val[i]) * 64'(held_wgt[best]);
					rhs = 64'(held_val[best]) * 64'(held_wgt[i]);
					if (!found || lhs >= rhs) begin
						best = i;
						found = 1'b1;
					end
				end
			end
			if (!found)
				break;
			if (64'(room) >= 64'(held_wgt[best])) begin
				gain = 64'(held_val[best]) << FRAC_W;
				room = room - CAP_W'(held_wgt[best]);
				held_wgt[best] = '0;
			end else begin
				gain = ((64'(held_val[best]) * 64'(room)) << FRAC_W) / 64'(held_wgt[best]);
				held_wgt[best] = held_wgt[best] - WGT_W'(room);
				room = '0;
				partial_picks++;
			end
			acc = acc + gain;
			if (acc > TOT_MAX)
				acc = TOT_MAX;
		end
		return acc[TOT_W-1:0];
	endfunction

	// Called at the edge where an item transaction completes.
	task automatic store_and_predict(input logic [VAL_W-1:0] v, input logic [WGT_W-1:0] w,
			input bit last, input bit hand_exp, input loot_t hand_loot);
		loot_t predicted;
		items_sent++;
		if (held_cnt < MAX_ITEMS) begin
			held_val[held_cnt] = v;
			held_wgt[held_cnt] = w;
			held_cnt++;
		end else begin
			spill_seen = 1'b1;
		end
		if (last) begin
			predicted.total = greedy_total();
			predicted.dropped = spill_seen;
			if (spill_seen)
				sets_spilled++;
			sets_done++;
			loot_q.push_back(hand_exp ? hand_loot : predicted);
			held_cnt = 0;
			spill_seen = 1'b0;
		end
	endtask

	task automatic send_item(input logic [VAL_W-1:0] v, input logic [WGT_W-1:0] w,
			input bit last, input bit hand_exp, input loot_t hand_loot);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		item_bus.valid <= 1'b1;
		item_bus.item_value <= v;
		item_bus.item_weight <= w;
		item_bus.last_item <= last;
		do @(posedge clk); while (!item_bus.ready);
		burst_left--;
		store_and_predict(v, w, last, hand_exp, hand_loot);
	endtask

	task automatic quiet_sender();
		item_bus.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic settle_until_idle();
		while (loot_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_capacity_reg();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(capacity_model)) begin
			$error("knapsack_capacity readback: expected %0d, got %0d", capacity_model, prdata);
			fail_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_capacity(input logic [CAP_W-1:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		capacity_model = cap;
		cap_writes++;
		check_capacity_reg();
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return VAL_MAX;
			2, 3, 4: return VAL_W'($urandom_range(0, 15));
			5, 6: return VAL_W'($urandom_range(0, 1023));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return WGT_MAX;
			2, 3, 4: return WGT_W'($urandom_range(1, 15));
			5: return WGT_W'($urandom_range(1, 1023));
			default: return WGT_W'($urandom);
		endcase
	endfunction

	// Mostly short sets; unless short_only, now and then a long one that may fill the store and spill.
	task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int quota,
			input bit short_only, input bit hold_sink);
		int sent;
		int len;
		quiet_sender();
		settle_until_idle();
		program_capacity(cap);
		// The receiver hold starts only once the phase is set up, so the sender meets it.
		if (hold_sink)
			hold_req = 1'b1;
		sent = 0;
		while (sent < quota) begin
			if (!short_only && $urandom_range(0, 11) == 0)
				len = $urandom_range(60, 72);
			else
				len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				send_item(rand_value(), rand_weight(), k == len - 1, 1'b0, '0);
			sent += len;
		end
	endtask

	initial begin : result_sink
		sink_mode_e mode;
		int mode_left;
		int tick;
		result_bus.ready <= 1'b0;
		mode = SINK_OPEN;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// Long hold-off so the output register and then the input side back up.
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				tick++;
				case (mode)
					SINK_OPEN: result_bus.ready <= 1'b1;
					SINK_RANDOM: result_bus.ready <= 1'($urandom_range(0, 1));
					default: result_bus.ready <= (tick % 5 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		loot_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			results_seen++;
			if (loot_q.size() == 0) begin
				$error("unexpected result transaction: total_value %0d, items_dropped %0d",
					result_bus.total_value, result_bus.items_dropped);
				fail_cnt++;
			end else begin
				want = loot_q.pop_front();
				if (result_bus.total_value !== want.total) begin
					$error("total_value mismatch: expected %0d, got %0d",
						want.total, result_bus.total_value);
					fail_cnt++;
				end
				if (result_bus.items_dropped !== want.dropped) begin
					$error("items_dropped mismatch: expected %0d, got %0d",
						want.dropped, result_bus.items_dropped);
					fail_cnt++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_bus.valid && item_bus.ready) ||
					(result_bus.valid && result_bus.ready) || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [CAP_W-1:0] phase_cap;
		loot_t hand_loot;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_bus.valid <= 1'b0;
		item_bus.item_value <= '0;
		item_bus.item_weight <= '0;
		item_bus.last_item <= 1'b0;
		held_cnt = 0;
		spill_seen = 1'b0;
		capacity_model = '0;
		fail_cnt = 0;
		burst_left = 0;
		hold_req = 1'b0;
		items_sent = 0;
		sets_done = 0;
		sets_spilled = 0;
		partial_picks = 0;
		cap_writes = 0;
		results_seen = 0;

		// Zero capacity, a lone zero-weight item, whole picks, extremes, ratio ties,
		// zero value with weight, partial picks and zero weight next to equal ratios.
		directed_tab = '{
			'{24'd0,      20'd1000,  20'd10,    1'b1, 1'b1, 42'd0,      1'b0},
			'{24'd100,    20'd0,     20'd0,     1'b1, 1'b1, 42'd0,      1'b0},
			'{24'd100,    20'd5,     20'd10,    1'b0, 1'b0, 42'd0,      1'b0},
			'{24'd100,    20'd0,     20'd0,     1'b0, 1'b0, 42'd0,      1'b0},
			'{24'd100,    20'd7,     20'd10,    1'b1, 1'b1, 42'd786432, 1'b0},
			'{CAP_MAX,    VAL_MAX,   WGT_MAX,   1'b0, 1'b0, 42'd0,      1'b0},
			'{CAP_MAX,    VAL_MAX,   20'd1,     1'b0, 1'b0, 42'd0,      1'b0},
			'{CAP_MAX,    20'd0,     20'd5,     1'b1, 1'b0, 42'd0,      1'b0},
			'{24'd5,      20'd3,     20'd6,     1'b0, 1'b0, 42'd0,      1'b0},
			'{24'd5,      20'd1,     20'd2,     1'b0, 1'b0, 42'd0,      1'b0},
			'{24'd5,      20'd2,     20'd4,     1'b1, 1'b0, 42'd0,      1'b0},
			'{24'd1,      VAL_MAX,   WGT_MAX,   1'b1, 1'b1, 42'd65536,  1'b0},
			'{24'd1,      20'd1,     WGT_MAX,   1'b1, 1'b0, 42'd0,      1'b0},
			'{24'h800000, VAL_MAX,   20'd3,     1'b0, 1'b0, 42'd0,      1'b0},
			'{24'h800000, 20'h80000, WGT_MAX,   1'b0, 1'b0, 42'd0,      1'b0},
			'{24'h800000, 20'd1,     20'd7,     1'b1, 1'b0, 42'd0,      1'b0},
			'{24'd3,      20'd10,    20'd0,     1'b0, 1'b0, 42'd0,      1'b0},
			'{24'd3,      20'd9,     20'd3,     1'b0, 1'b0, 42'd0,      1'b0},
			'{24'd3,      20'd9,     20'd3,     1'b1, 1'b0, 42'd0,      1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_capacity_reg();

		for (int i = 0; i < N_DIRECTED; i++) begin
			if ((i == 0 || directed_tab[i-1].last) && directed_tab[i].cap != capacity_model) begin
				quiet_sender();
				settle_until_idle();
				program_capacity(directed_tab[i].cap);
			end
			hand_loot.total = directed_tab[i].hand_total;
			hand_loot.dropped = directed_tab[i].hand_dropped;
			send_item(directed_tab[i].value, directed_tab[i].weight, directed_tab[i].last,
				directed_tab[i].hand_exp, hand_loot);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_cap = CAP_MAX;
				1: phase_cap = 24'd1;
				2: phase_cap = CAP_W'($urandom_range(2, 64));
				3: phase_cap = CAP_W'($urandom_range(1024, 1 << 21));
				4: phase_cap = '0;
				default: phase_cap = CAP_W'($urandom);
			endcase
			// The small-capacity phase computes fast, so a long receiver hold fills the block.
			run_random_phase(phase_cap, RANDOM_ITEMS / RANDOM_PHASES, p == 2, p == 2);
		end

		quiet_sender();
		while (loot_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items in %0d sets (%0d sets spilled past the store), %0d results.",
			items_sent, sets_done, sets_spilled, results_seen);
		$display("Made %0d partial picks across %0d capacity writes.", partial_picks, cap_writes);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
src/fks_pkg.sv
src/fks_if.sv
src/fks_ram.sv
src/fks_ctrl.sv
src/fks_dp.sv
src/fractional_knapsack_greedy.sv
sim/tb_fractional_knapsack_greedy.sv
